>>> hdl/mms_pkg.sv
// Package: shared types and constants for the max-min spacing search block.
package mms_pkg;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int POS_WIDTH_DEF  = 32;
  localparam int BALL_W         = 11;
  localparam int GAP_W          = 32;
  localparam logic [BALL_W-1:0] BALL_RESET = 11'd2;

  typedef struct packed {
    logic [POS_WIDTH_DEF-1:0] point_position;
    logic                     last_point;
  } in_item_t;

  typedef struct packed {
    logic [GAP_W-1:0] best_gap;
    logic             overflowed;
  } out_item_t;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_SORT_R = 11'b00000000010,
    ST_SORT_V = 11'b00000000100,
    ST_SORT_C = 11'b00000001000,
    ST_INIT   = 11'b00000010000,
    ST_MID    = 11'b00000100000,
    ST_FIRST  = 11'b00001000000,
    ST_DECIDE = 11'b00010000000,
    ST_PASS_R = 11'b00100000000,
    ST_PASS_C = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } state_e;
endpackage

>>> hdl/max_min_spacing_search.sv
// Top level: point loader, insertion sort and binary search on the gap.
//
// Load one point per cycle with start while busy is low; a point flagged
// last_point starts the search and busy stays high until the single result
// strobes for one cycle (the receiver cannot stall). The point memory has one
// write port and one registered read port. While busy, the block runs an
// insertion sort of the n stored points, with S element shifts (at most
// n*(n-1)/2, zero for ascending input), then k binary-search steps (at most
// POS_WIDTH), each of which runs a greedy pass over every stored point. The
// result strobes in the first cycle that busy is low again, and a new point
// may be accepted in that cycle.
// Points beyond MAX_POINTS are dropped and flagged in the result.
module max_min_spacing_search #(
  parameter int MAX_POINTS = mms_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mms_pkg::in_item_t           item_i,
  input  logic                        cfg_we_i,
  input  logic [mms_pkg::BALL_W-1:0]  cfg_data_i,
  output logic                        done_o,
  output mms_pkg::out_item_t          result_o
);
  import mms_pkg::*;

  localparam int PW = POS_WIDTH_DEF;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int TW = (CW > BALL_W) ? CW : BALL_W;

  logic [PW-1:0] mem_q [MAX_POINTS];
  logic [PW-1:0] rd_q;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [PW-1:0] wd;

  state_e            st_q;
  logic [BALL_W-1:0] ball_q;
  logic [CW-1:0]     cnt_q, i_q, j_q, taken_q;
  logic [PW-1:0]     v_q, lo_q, hi_q, mid_q, prev_q;
  logic              ovf_q;
  logic [PW:0]       diff;
  logic              cnt_room;
  logic              shift_up;

  // point memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  assign busy     = (st_q != ST_IDLE);
  assign diff     = {1'b0, hi_q} - {1'b0, lo_q};
  assign cnt_room = (cnt_q < CW'(MAX_POINTS));
  assign shift_up = (j_q != '0) && (rd_q > v_q);

  // drive memory port
  always_comb begin
    we = 1'b0;
    wa = cnt_q[AW-1:0];
    wd = item_i.point_position;
    ra = '0;
    case (st_q)
      ST_IDLE:   we = start && cnt_room;
      ST_SORT_R: ra = i_q[AW-1:0];
      ST_SORT_V: ra = j_q[AW-1:0] - AW'(1);
      ST_SORT_C: begin
        we = 1'b1;
        wa = j_q[AW-1:0];
        wd = shift_up ? rd_q : v_q;
        ra = j_q[AW-1:0] - AW'(2);
      end
      ST_INIT:   ra = cnt_q[AW-1:0] - AW'(1);
      ST_PASS_R: ra = i_q[AW-1:0];
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ball_q <= BALL_RESET; cnt_q <= '0; ovf_q <= 1'b0;
      i_q <= '0; j_q <= '0; taken_q <= '0;
      v_q <= '0; lo_q <= '0; hi_q <= '0; mid_q <= '0; prev_q <= '0;
      done_o <= 1'b0; result_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) ball_q <= cfg_data_i;
      case (st_q)
        ST_IDLE: begin
          if (start) begin
            if (cnt_room) cnt_q <= cnt_q + CW'(1);
            else ovf_q <= 1'b1;
            if (item_i.last_point) begin
              i_q <= CW'(1);
              st_q <= ST_SORT_R;
            end
          end
        end
        // fetch element i for insertion
        ST_SORT_R: begin
          if (i_q >= cnt_q) st_q <= ST_INIT;
          else begin
            j_q <= i_q;
            st_q <= ST_SORT_V;
          end
        end
        ST_SORT_V: begin
          v_q <= rd_q;
          st_q <= ST_SORT_C;
        end
        // shift larger neighbors up, then drop v into its slot
        ST_SORT_C: begin
          if (shift_up) j_q <= j_q - CW'(1);
          else begin
            i_q <= i_q + CW'(1);
            st_q <= ST_SORT_R;
          end
        end
        ST_INIT: st_q <= ST_MID;
        ST_MID: begin
          hi_q <= rd_q;
          lo_q <= '0;
          st_q <= ST_FIRST;
        end
        ST_FIRST: begin
          v_q <= rd_q;
          st_q <= ST_DECIDE;
        end
        // pick the next trial gap or finish
        ST_DECIDE: begin
          if (lo_q < hi_q) begin
            mid_q <= lo_q + diff[PW:1] + PW'(diff[0]);
            taken_q <= CW'(1);
            prev_q <= v_q;
            i_q <= CW'(1);
            st_q <= ST_PASS_R;
          end else st_q <= ST_DONE;
        end
        // read the next point; at the end of a greedy pass, narrow the bounds
        ST_PASS_R: begin
          if (i_q >= cnt_q) begin
            if (TW'(taken_q) >= TW'(ball_q)) lo_q <= mid_q;
            else hi_q <= mid_q - PW'(1);
            st_q <= ST_DECIDE;
          end else st_q <= ST_PASS_C;
        end
        ST_PASS_C: begin
          if (rd_q - prev_q >= mid_q) begin
            prev_q <= rd_q;
            taken_q <= taken_q + CW'(1);
          end
          i_q <= i_q + CW'(1);
          st_q <= ST_PASS_R;
        end
        ST_DONE: begin
          done_o <= 1'b1;
          result_o.best_gap <= GAP_W'(lo_q);
          result_o.overflowed <= ovf_q;
          cnt_q <= '0; ovf_q <= 1'b0;
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule
